// ===== hdl/pulse_beat_rate_tracker_defines.svh =====
// Assertion macros shared by the pulse beat rate tracker RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef PULSE_BEAT_RATE_TRACKER_DEFINES_SVH
`define PULSE_BEAT_RATE_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBRT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBRT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pbrt_pkg.sv =====
// Package for the pulse beat rate tracker: field widths, register indexes,
// reset values and the types shared between the front end, queue and back end.
`timescale 1ns / 1ps

package pbrt_pkg;

  localparam int TIME_W  = 32;
  localparam int IR_W    = 18;
  localparam int RATE_W  = 16;
  localparam int DC_W    = 24;
  localparam int ARM_W   = 10;
  localparam int TRIG_W  = 11;
  localparam int INTV_W  = 16;
  // AC value range: ir minus ceil(dc/16), which fits in 22 signed bits.
  localparam int AC_W    = 22;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESENCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ARM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRIGGER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_INTV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_INTV = 3'd4;

  localparam logic [IR_W-1:0]   PRESENCE_RST = 18'd8000;
  localparam logic [ARM_W-1:0]  ARM_RST      = 10'd20;
  localparam logic [TRIG_W-1:0] TRIGGER_RST  = 11'h7F6;  // -10
  localparam logic [INTV_W-1:0] MIN_INTV_RST = 16'd333;
  localparam logic [INTV_W-1:0] MAX_INTV_RST = 16'd1500;

  // Milliseconds per minute, the numerator of the rate.
  localparam logic [RATE_W-1:0] RATE_NUM = 16'd60000;
  localparam logic [RATE_W-1:0] RATE_MAX = 16'd60000;

  localparam int JOB_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [IR_W-1:0]          presence;
    logic [ARM_W-1:0]         arm;
    logic signed [TRIG_W-1:0] trigger;
    logic [INTV_W-1:0]        min_intv;
    logic [INTV_W-1:0]        max_intv;
  } cfg_t;

  // One accepted beat handed from the front end to the back end.
  typedef struct packed {
    logic [INTV_W-1:0] delta;
  } job_t;

endpackage

// ===== hdl/pulse_beat_rate_tracker.sv =====
// Top level of the pulse beat rate tracker: configuration registers and
// the stream ports. Depends on pbrt_pkg, pbrt_front, pbrt_fifo and pbrt_back.
`timescale 1ns / 1ps

// The tracker takes one optical pulse sample per input beat (timestamp,
// enable flag, infrared reading) and produces one output beat for every
// heartbeat whose interval lies strictly between the configured bounds,
// carrying 60000/interval and the floor mean of the nonzero rate history.
// Samples that do not yield a heartbeat produce no output. The front end
// takes a sample every cycle as long as its two-entry beat queue has room;
// the back end takes the next beat from the queue only once it has handed
// the last result to the output register. Its single serial divider, of
// SUM_W bits where SUM_W is 16 plus log2 of HISTORY_DEPTH, computes first
// the rate and then the average at one bit per cycle, and between the two
// the back end walks over the history one entry per cycle. Configuration is
// written through the cfg port, which is always ready; writes should only
// happen while no heartbeat is in flight. After reset the thresholds hold
// 8000, 20, -10, 333 ms and 1500 ms and the rate history is empty.

module pulse_beat_rate_tracker #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbrt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pbrt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Sample stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [55:0]                         s_axis_tdata,  // time_ms[31:0], ir_sample[49:32], zero
  input  logic [0:0]                          s_axis_tuser,  // enabled
  // Heartbeat stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata   // instant_rate[15:0], average_rate[31:16]
);
  import pbrt_pkg::*;

  cfg_t              cfg_q;
  logic              accept;
  logic              push, full, pop, empty;
  job_t              push_data, pop_data;
  logic [RATE_W-1:0] rate, avg;

  assign cfg_ready_o = 1'b1;

  // Each register takes the low bits of the write data that fit its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.presence <= PRESENCE_RST;
      cfg_q.arm      <= ARM_RST;
      cfg_q.trigger  <= TRIGGER_RST;
      cfg_q.min_intv <= MIN_INTV_RST;
      cfg_q.max_intv <= MAX_INTV_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_PRESENCE: cfg_q.presence <= cfg_data_i[IR_W-1:0];
        CFG_IDX_ARM:      cfg_q.arm      <= cfg_data_i[ARM_W-1:0];
        CFG_IDX_TRIGGER:  cfg_q.trigger  <= cfg_data_i[TRIG_W-1:0];
        CFG_IDX_MIN_INTV: cfg_q.min_intv <= cfg_data_i[INTV_W-1:0];
        CFG_IDX_MAX_INTV: cfg_q.max_intv <= cfg_data_i[INTV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A sample is taken only while the queue can hold the beat it may cause.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  pbrt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .time_i     (s_axis_tdata[TIME_W-1:0]),
    .enabled_i  (s_axis_tuser[0]),
    .ir_i       (s_axis_tdata[TIME_W+IR_W-1:TIME_W]),
    .push_o     (push),
    .push_data_o(push_data)
  );

  pbrt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  pbrt_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(empty),
    .job_i      (pop_data),
    .job_pop_o  (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_rate_o (rate),
    .out_avg_o  (avg)
  );

  assign m_axis_tdata = {avg, rate};

endmodule

// ===== hdl/pbrt_fifo.sv =====
// Two-entry queue of accepted beats between the front end and the back end.
// Depends on pbrt_pkg for the beat type and the queue depth.
`timescale 1ns / 1ps
`include "pulse_beat_rate_tracker_defines.svh"

module pbrt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbrt_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output pbrt_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import pbrt_pkg::*;

  localparam int PTR_W = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

  job_t             mem_q [JOB_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == CNT_W'(JOB_FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `PBRT_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(JOB_FIFO_DEPTH), "queue count beyond depth")
  `PBRT_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, full_o, !push_i, "push into full queue")
  `PBRT_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, empty_o, !pop_i, "pop from empty queue")

endmodule

// ===== hdl/pbrt_front.sv =====
// Front end: DC tracker, arm and fire detector and interval window check.
// Depends on pbrt_pkg; pushes accepted beats into pbrt_fifo.
`timescale 1ns / 1ps

module pbrt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pbrt_pkg::cfg_t                cfg_i,
  input  logic                          accept_i,
  input  logic [pbrt_pkg::TIME_W-1:0]   time_i,
  input  logic                          enabled_i,
  input  logic [pbrt_pkg::IR_W-1:0]     ir_i,
  output logic                          push_o,
  output pbrt_pkg::job_t                push_data_o
);
  import pbrt_pkg::*;

  logic [DC_W-1:0]          dc_q;
  logic                     armed_q;
  logic [TIME_W-1:0]        last_q;

  logic [DC_W-1:0]          w_eff;
  logic [DC_W-4:0]          ceil16;
  logic signed [AC_W-1:0]   ac;
  logic [DC_W-1:0]          dc_new;
  logic                     present, arm_hit, trig_hit, fire;
  logic [TIME_W-1:0]        delta;
  logic                     big, gt_min, lt_max, in_win;

  // An empty tracker is seeded with 16 * ir, which yields an AC value of 0.
  assign w_eff  = (dc_q == '0) ? {2'b00, ir_i, 4'b0000} : dc_q;
  // ir + floor(15w/16) - w equals ir - ceil(w/16), and never leaves 24 bits.
  assign ceil16 = {1'b0, w_eff[DC_W-1:4]} + (DC_W-3)'(|w_eff[3:0]);
  assign ac     = $signed({4'b0000, ir_i}) - $signed({1'b0, ceil16});
  // The AC value is sign extended, so a falling signal lowers the tracker.
  assign dc_new = w_eff + {{(DC_W-AC_W){ac[AC_W-1]}}, ac};

  assign present  = enabled_i && (ir_i >= cfg_i.presence);
  assign arm_hit  = ac > $signed({12'd0, cfg_i.arm});
  assign trig_hit = ac < $signed({{(AC_W-TRIG_W){cfg_i.trigger[TRIG_W-1]}}, cfg_i.trigger});
  // Arming is tested first, so one sample may arm and fire.
  assign fire     = (armed_q || arm_hit) && trig_hit;

  assign delta  = time_i - last_q;
  assign big    = |delta[TIME_W-1:INTV_W];
  assign gt_min = big || (delta[INTV_W-1:0] > cfg_i.min_intv);
  assign lt_max = !big && (delta[INTV_W-1:0] < cfg_i.max_intv);
  assign in_win = gt_min && lt_max;

  assign push_o            = accept_i && present && fire && in_win;
  assign push_data_o.delta = delta[INTV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= '0;
      armed_q <= 1'b0;
      last_q  <= '0;
    end else if (accept_i) begin
      if (!present) begin
        dc_q    <= '0;
        armed_q <= 1'b0;
      end else begin
        dc_q    <= dc_new;
        armed_q <= fire ? 1'b0 : (armed_q || arm_hit);
        // Too-long intervals restart timing; too-short ones leave it alone.
        if (fire && (in_win || !lt_max)) begin
          last_q <= time_i;
        end
      end
    end
  end

endmodule

// ===== hdl/pbrt_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Stand-alone; shared by the back end for the rate and the average.
`timescale 1ns / 1ps

module pbrt_div #(
  parameter int DVD_W = 18,
  parameter int DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;

  logic [DVS_W:0]    trial;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = !diff[DVS_W+1];

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/pbrt_back.sv =====
// Back end: rate division, rate history, averaging and the output register.
// Depends on pbrt_pkg and pbrt_div; takes beats from pbrt_fifo.
`timescale 1ns / 1ps
`include "pulse_beat_rate_tracker_defines.svh"

module pbrt_back #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_empty_i,
  input  pbrt_pkg::job_t                job_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pbrt_pkg::RATE_W-1:0]   out_rate_o,
  output logic [pbrt_pkg::RATE_W-1:0]   out_avg_o
);
  import pbrt_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = RATE_W + $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE,
    B_RATE,
    B_SUM,
    B_AVG,
    B_HOLD
  } back_state_e;

  back_state_e       state_q;
  logic [RATE_W-1:0] hist_q [HISTORY_DEPTH];
  logic [IDX_W-1:0]  ptr_q, idx_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RATE_W-1:0] rate_q, avg_q;
  logic [RATE_W-1:0] beat_rate_q, beat_avg_q;
  logic              out_valid_q;

  logic              div_start_q, div_start_d;
  logic [SUM_W-1:0]  div_dvd_q;
  logic [RATE_W-1:0] div_dvs_q;
  logic              div_busy, div_done;
  logic [SUM_W-1:0]  div_quo;

  logic [RATE_W-1:0] hist_rd;
  logic              nz;
  logic [SUM_W-1:0]  sum_nx;
  logic [CNT_W-1:0]  cnt_nx;
  logic              out_load;

  pbrt_div #(
    .DVD_W(SUM_W),
    .DVS_W(RATE_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dvd_q),
    .divisor_i (div_dvs_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign hist_rd = hist_q[idx_q];
  assign nz      = (hist_rd != '0);
  assign sum_nx  = sum_q + (nz ? SUM_W'(hist_rd) : '0);
  assign cnt_nx  = cnt_q + CNT_W'(nz);

  // The divider starts for the rate when a beat is taken, and for the average
  // at the end of the history walk when at least one entry is nonzero.
  assign div_start_d = ((state_q == B_IDLE) && !job_empty_i) ||
                       ((state_q == B_SUM) && (idx_q == IDX_W'(HISTORY_DEPTH - 1)) &&
                        (cnt_nx != '0));
  // A finished result moves to the output register once that register is free.
  assign out_load    = (state_q == B_HOLD) && (!out_valid_q || out_ready_i);

  assign job_pop_o   = (state_q == B_IDLE) && !job_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_rate_o  = rate_q;
  assign out_avg_o   = avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ptr_q       <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
      rate_q      <= '0;
      avg_q       <= '0;
      beat_rate_q <= '0;
      beat_avg_q  <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      div_start_q <= div_start_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        rate_q      <= beat_rate_q;
        avg_q       <= beat_avg_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            div_dvd_q   <= SUM_W'(RATE_NUM);
            div_dvs_q   <= job_i.delta;
            state_q     <= B_RATE;
          end
        end
        B_RATE: begin
          if (div_done) begin
            // A zero rate lands in the history as an empty entry.
            beat_rate_q   <= div_quo[RATE_W-1:0];
            hist_q[ptr_q] <= div_quo[RATE_W-1:0];
            ptr_q <= (ptr_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
            idx_q   <= '0;
            sum_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_SUM;
          end
        end
        B_SUM: begin
          sum_q <= sum_nx;
          cnt_q <= cnt_nx;
          if (idx_q == IDX_W'(HISTORY_DEPTH - 1)) begin
            if (cnt_nx == '0) begin
              beat_avg_q <= '0;
              state_q    <= B_HOLD;
            end else begin
              div_dvd_q   <= sum_nx;
              div_dvs_q   <= RATE_W'(cnt_nx);
              state_q     <= B_AVG;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        B_AVG: begin
          if (div_done) begin
            beat_avg_q <= div_quo[RATE_W-1:0];
            state_q    <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (out_load) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  `PBRT_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_q, (rate_q <= RATE_MAX) && (avg_q <= RATE_MAX), "result beyond 60000")
  `PBRT_ASSERT_IMP(a_idle_div, clk_i, rst_ni, state_q == B_IDLE, !div_busy, "divider busy while idle")
  `PBRT_ASSERT_IMP(a_done_state, clk_i, rst_ni, div_done, (state_q == B_RATE) || (state_q == B_AVG), "divider done outside a divide state")

endmodule

// ===== tb/pulse_beat_rate_tracker_tb.sv =====
// Self-checking testbench for the pulse beat rate tracker top level.
// Depends on pbrt_pkg and the pulse_beat_rate_tracker RTL; it needs no other file.
`timescale 1ns / 1ps

// The bench drives optical pulse samples into the sample stream and checks every
// heartbeat beat that comes out of the heartbeat stream against a heartbeat
// predictor that runs alongside the block. The predictor keeps its own copy of
// the DC tracker, the arm flag, the last beat time, the rate history and the
// five threshold registers.
//
// Stimulus is fed through a queue of pending samples. An initial block fills
// that queue one register setting at a time: first a short directed run at the
// reset values, then mostly synthetic finger sessions (steady baseline, a rise
// that arms the detector and a drop that fires it, with beat intervals aimed
// inside, on and outside the bounds) mixed with noise samples. A clocked driver
// pops the queue onto the sample stream and runs the predictor on every
// accepted beat. A clocked monitor takes heartbeat beats and compares them
// with the oldest prediction. Both sides idle in random bursts, except during
// the last setting.
//
// Two special cases of the block are not reached by the settings of this bench:
// a zero rate needs an interval above 60000 ms while the upper bound is set to
// at most 60000, and arming and firing on one sample needs a trigger level above
// the arm level while the trigger level is never set positive. An empty history
// never shows on the output either, since a heartbeat always stores a nonzero rate.

module pulse_beat_rate_tracker_tb;
  import pbrt_pkg::*;

  localparam int HIST_DEPTH = 4;
  // Two heartbeats may be queued ahead of the back end.
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IR_MAX = 262143;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              enabled;
    logic [IR_W-1:0]   ir;
  } sample_t;

  typedef struct packed {
    logic [RATE_W-1:0] instant;
    logic [RATE_W-1:0] average;
  } heartbeat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  pulse_beat_rate_tracker #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of the registers, reset to the block's reset values.
  cfg_t cfg_model = '{presence: PRESENCE_RST, arm: ARM_RST, trigger: TRIGGER_RST,
                      min_intv: MIN_INTV_RST, max_intv: MAX_INTV_RST};

  // Predictor copy of the detector state.
  logic [DC_W-1:0]   dc_acc = '0;
  logic              armed = 1'b0;
  logic [TIME_W-1:0] last_beat = '0;
  logic [RATE_W-1:0] rate_hist [HIST_DEPTH] = '{default: '0};
  int                hist_ptr = 0;

  sample_t    sample_q[$];     // samples waiting for the driver
  sample_t    staged_q[$];     // samples being built for the next setting
  heartbeat_t heartbeat_q[$];  // predicted heartbeats not yet seen

  logic [TIME_W-1:0] clock_ms = '0;  // timestamp cursor of the generator
  bit  idle_en = 1'b1;
  int  gap_left = 0;
  int  stall_left = 0;
  int  error_count = 0;
  int  samples_sent = 0;
  int  heartbeats_seen = 0;
  int  settings_count = 1;
  longint cycle_count = 0;

  // Runs one sample through the predicted detector. Returns 1 and fills hb when
  // the sample completes a heartbeat whose interval is within the bounds.
  function automatic bit predict_heartbeat(input sample_t s, output heartbeat_t hb);
    logic [DC_W-1:0]   old_w;
    int                ac;
    int                trig;
    logic [TIME_W-1:0] delta;
    logic [RATE_W-1:0] rate;
    int unsigned       sum;
    int unsigned       cnt;
    hb = '0;
    sum = 0;
    cnt = 0;
    trig = $signed(cfg_model.trigger);
    // No finger or disabled: the tracker and the arm flag start over.
    if (!s.enabled || s.ir < cfg_model.presence) begin
      dc_acc = '0;
      armed = 1'b0;
      return 1'b0;
    end
    // An empty tracker is seeded at its steady state, so the AC value is zero.
    if (dc_acc == '0) dc_acc = DC_W'({s.ir, 4'b0000});
    old_w = dc_acc;
    dc_acc = DC_W'(32'(s.ir) + ((32'(old_w) * 32'd15) >> 4));
    ac = int'({8'b0, dc_acc}) - int'({8'b0, old_w});
    if (ac > int'({22'b0, cfg_model.arm})) armed = 1'b1;
    if (!(armed && ac < trig)) return 1'b0;
    armed = 1'b0;
    delta = s.time_ms - last_beat;
    if (delta > cfg_model.min_intv && delta < cfg_model.max_intv) begin
      rate = RATE_W'(32'(RATE_NUM) / delta);
      rate_hist[hist_ptr] = rate;
      hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
      foreach (rate_hist[i]) begin
        if (rate_hist[i] != '0) begin
          sum += rate_hist[i];
          cnt++;
        end
      end
      hb.instant = rate;
      hb.average = (cnt != 0) ? RATE_W'(sum / cnt) : '0;
      last_beat = s.time_ms;
      return 1'b1;
    end
    // A long gap restarts the timing; a short one is simply dropped.
    if (delta >= cfg_model.max_intv) last_beat = s.time_ms;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("MISMATCH at heartbeat %0d: %s, expected %0d, got %0d",
             heartbeats_seen, what, exp_v, got_v);
    error_count++;
  endtask

  // Sample driver: one item per beat, with random idle bursts between items.
  // A beat that is offered is held until the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    heartbeat_t hb;
    bit next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_heartbeat(sample_q.pop_front(), hb)) heartbeat_q.push_back(hb);
        samples_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() != 0) begin
          if (idle_en && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
          end else begin
            next_valid = 1'b1;
            s_axis_tdata <= {6'b0, sample_q[0].ir, sample_q[0].time_ms};
            s_axis_tuser <= sample_q[0].enabled;
          end
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // Heartbeat monitor: checks each beat against the oldest prediction and
  // stalls the block in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin : heartbeat_monitor
    heartbeat_t hb;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        heartbeats_seen++;
        if (heartbeat_q.size() == 0) begin
          report_mismatch("heartbeat with none predicted", '0, m_axis_tdata);
        end else begin
          hb = heartbeat_q.pop_front();
          if (m_axis_tdata[15:0] !== hb.instant)
            report_mismatch("instant_rate", 32'(hb.instant), 32'(m_axis_tdata[15:0]));
          if (m_axis_tdata[31:16] !== hb.average)
            report_mismatch("average_rate", 32'(hb.average), 32'(m_axis_tdata[31:16]));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d heartbeats outstanding",
               cycle_count, heartbeat_q.size());
      $display("pulse_beat_rate_tracker test failed");
      $finish;
    end
  end

  // Writes one register and mirrors it into the predictor once it is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_IDX_PRESENCE: cfg_model.presence = val;
      CFG_IDX_ARM:      cfg_model.arm = val[ARM_W-1:0];
      CFG_IDX_TRIGGER:  cfg_model.trigger = val[TRIG_W-1:0];
      CFG_IDX_MIN_INTV: cfg_model.min_intv = val[INTV_W-1:0];
      CFG_IDX_MAX_INTV: cfg_model.max_intv = val[INTV_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_config(input cfg_t c);
    write_reg(CFG_IDX_PRESENCE, CFG_DATA_W'(c.presence));
    write_reg(CFG_IDX_ARM, CFG_DATA_W'(c.arm));
    write_reg(CFG_IDX_TRIGGER, CFG_DATA_W'(c.trigger));
    write_reg(CFG_IDX_MIN_INTV, CFG_DATA_W'(c.min_intv));
    write_reg(CFG_IDX_MAX_INTV, CFG_DATA_W'(c.max_intv));
    settings_count++;
  endtask

  function automatic cfg_t make_cfg(input int pres, input int arm_v, input int trig_v,
                                    input int min_v, input int max_v);
    cfg_t c;
    c.presence = IR_W'(pres);
    c.arm      = ARM_W'(arm_v);
    c.trigger  = TRIG_W'(trig_v);
    c.min_intv = INTV_W'(min_v);
    c.max_intv = INTV_W'(max_v);
    return c;
  endfunction

  function automatic void stage(input logic [TIME_W-1:0] t, input logic en,
                                input int ir);
    sample_t s;
    s.time_ms = t;
    s.enabled = en;
    s.ir      = IR_W'(ir);
    staged_q.push_back(s);
  endfunction

  // One directed heartbeat: baseline, rise and drop, the drop landing on fire_t.
  function automatic void stage_beat(input logic [TIME_W-1:0] fire_t);
    logic [TIME_W-1:0] span;
    span = fire_t - clock_ms;
    stage(clock_ms + span / 3, 1'b1, 100000);
    stage(clock_ms + 2 * (span / 3), 1'b1, 100200);
    stage(fire_t, 1'b1, 99800);
    clock_ms = fire_t;
  endfunction

  // Beat interval: mostly inside the bounds, sometimes right on them, and
  // sometimes anywhere, including beyond the largest bound.
  function automatic int pick_interval();
    int lo;
    int hi;
    int pick;
    lo = int'(cfg_model.min_intv);
    hi = int'(cfg_model.max_intv);
    pick = $urandom_range(0, 19);
    if (pick < 13) return (lo + 1 <= hi - 1) ? $urandom_range(lo + 1, hi - 1)
                                             : $urandom_range(1, 2000);
    if (pick < 17) begin
      case ($urandom_range(0, 3))
        0: return lo;
        1: return lo + 1;
        2: return hi - 1;
        default: return hi;
      endcase
    end
    return $urandom_range(0, 70000);
  endfunction

  function automatic void stage_noise(input int n);
    int p;
    int ir;
    p = int'(cfg_model.presence);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: ir = $urandom_range(0, IR_MAX);
        1: ir = (p > 0) ? p - 1 : 0;
        2: ir = p;
        3: ir = IR_MAX;
        4: ir = 0;
        default: ir = $urandom_range(p, IR_MAX);
      endcase
      if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, 40);
      stage(clock_ms, $urandom_range(0, 7) != 0, ir);
    end
  endfunction

  // A finger session: a steady baseline with a run of heartbeats, each made
  // of a few baseline samples, a rise that should arm and a drop that should
  // fire. Now and then the rise is too weak, so the beat is missed.
  function automatic void stage_session(input int n_beats);
    int arm_v;
    int trig_mag;
    int up;
    int dn;
    int lo;
    int hi;
    int base;
    int intv;
    int k;
    int step;
    int ir;
    arm_v = int'(cfg_model.arm);
    trig_mag = -int'($signed(cfg_model.trigger));
    up = ($urandom_range(0, 7) == 0) ? $urandom_range(0, arm_v + 5)
                                     : arm_v + $urandom_range(1, 150);
    dn = trig_mag + $urandom_range(1, 150);
    lo = int'(cfg_model.presence) + dn + 16;
    hi = IR_MAX - up - 16;
    if (lo > hi) begin
      stage_noise(3 * n_beats);
      return;
    end
    base = $urandom_range(lo, hi);
    if ($urandom_range(0, 1) == 0) stage(clock_ms, 1'b0, base);
    // Some sessions start just short of the timestamp wrap.
    if ($urandom_range(0, 7) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    repeat (n_beats) begin
      intv = pick_interval();
      k = $urandom_range(3, 6);
      step = intv / k;
      for (int j = 0; j < k; j++) begin
        clock_ms += (j == k - 1) ? intv - step * (k - 1) : step;
        if (j == k - 2) ir = base + up;
        else if (j == k - 1) ir = base - dn;
        else ir = base + $urandom_range(0, 6) - 3;
        stage(clock_ms, 1'b1, ir);
      end
    end
  endfunction

  function automatic void stage_random(input int n);
    while (staged_q.size() < n) begin
      if ($urandom_range(0, 9) < 8) stage_session($urandom_range(1, 6));
      else stage_noise($urandom_range(1, 5));
    end
  endfunction

  // Hands the staged samples to the driver away from the clock edge, then
  // waits until the block has answered all of them and has gone quiet.
  task automatic run_staged(input bit with_idle);
    @(negedge clk_i);
    idle_en = with_idle;
    foreach (staged_q[i]) sample_q.push_back(staged_q[i]);
    staged_q.delete();
    @(posedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || heartbeat_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_setting(input cfg_t c, input int n, input bit with_idle);
    program_config(c);
    stage_random(n);
    run_staged(with_idle);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed run at the reset values: field extremes, disabled, below and at
    // the presence level, seeding, intervals on and next to both bounds, a
    // restart of the timing and an interval across the timestamp wrap.
    stage(32'h0000_0000, 1'b0, 0);
    stage(32'hFFFF_FFFF, 1'b1, IR_MAX);
    stage(32'd2, 1'b1, 7999);
    stage(32'd3, 1'b1, 8000);
    clock_ms = 32'd5;
    stage_beat(32'd1000);
    stage_beat(32'd1333);
    stage_beat(32'd1334);
    stage_beat(32'd2834);
    stage_beat(32'd4333);
    stage_beat(32'hFFFF_FF00);
    stage_beat(32'h0000_01F4);
    run_staged(1'b1);

    run_setting(make_cfg(1000, 20, -10, 300, 2000), 110, 1'b1);
    // Lowest thresholds and the widest window.
    run_setting(make_cfg(0, 0, 0, 0, 60000), 100, 1'b1);
    // Highest thresholds; the window is empty.
    run_setting(make_cfg(IR_MAX, 1023, -1024, 60000, 60000), 60, 1'b1);
    // Upper bound of 1 ms; the window is empty.
    run_setting(make_cfg(5000, 50, -40, 0, 1), 80, 1'b1);
    repeat (3) begin
      int mn;
      mn = $urandom_range(50, 800);
      run_setting(make_cfg($urandom_range(0, 60000), $urandom_range(0, 300),
                           -$urandom_range(0, 300), mn, mn + $urandom_range(2, 3000)),
                  110, 1'b1);
    end
    // Back to the reset values, with both sides running flat out.
    run_setting(make_cfg(int'(PRESENCE_RST), int'(ARM_RST), $signed(TRIGGER_RST),
                         int'(MIN_INTV_RST), int'(MAX_INTV_RST)), 110, 1'b0);

    $display("Drove %0d samples under %0d register settings and checked %0d heartbeats.",
             samples_sent, settings_count, heartbeats_seen);
    if (error_count == 0) begin
      $display("pulse_beat_rate_tracker test passed");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("pulse_beat_rate_tracker test failed");
    end
    $finish;
  end

endmodule
